// ----- sv/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, codes and types of the block slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Request and result field widths.
  localparam int unsigned OPCODE_W      = 2;
  localparam int unsigned BLOCK_ID_W    = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned SLOT_W        = 8;
  localparam int unsigned OFFSET_W      = 28;

  // Configuration port.
  localparam int unsigned BLOCK_BYTES_W = 21;
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RESET = BLOCK_BYTES_W'(4096);

  // Register indexes, taken from paddr[2].
  localparam logic REG_BLOCK_BYTES = 1'b0;

  // Request opcodes.
  localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_EVICT  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // Controller states.
  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_POP    = 7'b0010000,
    S_MUL    = 7'b0100000,
    S_DONE   = 7'b1000000
  } bsa_state_e;

endpackage

// ----- sv/bsa_if.sv -----
// ----------------------------------------------------------------------------
// bsa_req_if / bsa_rsp_if
// Valid/ready channels carrying requests into and results out of the block.
// ----------------------------------------------------------------------------
interface bsa_req_if;
  logic                             valid;
  logic                             ready;
  logic [bsa_pkg::OPCODE_W-1:0]     opcode;
  logic [bsa_pkg::BLOCK_ID_W-1:0]   block_id;

  modport source (output valid, output opcode, output block_id, input ready);
  modport sink   (input valid, input opcode, input block_id, output ready);
endinterface

interface bsa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [bsa_pkg::STATUS_W-1:0]     status;
  logic                             hit;
  logic [bsa_pkg::SLOT_W-1:0]       slot_index;
  logic [bsa_pkg::OFFSET_W-1:0]     byte_offset;

  modport source (output valid, output status, output hit, output slot_index,
                  output byte_offset, input ready);
  modport sink   (input valid, input status, input hit, input slot_index,
                  input byte_offset, output ready);
endinterface

// ----- sv/bsa_cfg.sv -----
// ----------------------------------------------------------------------------
// bsa_cfg
// APB-style register file holding the block size.
// ----------------------------------------------------------------------------
module bsa_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bsa_pkg::PADDR_W-1:0]       paddr,
  input  logic [bsa_pkg::PDATA_W-1:0]       pwdata,
  output logic [bsa_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  output logic [bsa_pkg::BLOCK_BYTES_W-1:0] block_bytes_o
);

  logic [bsa_pkg::BLOCK_BYTES_W-1:0] block_bytes_q;
  logic [bsa_pkg::BLOCK_BYTES_W-1:0] block_bytes_d;
  logic                              wr_block_bytes;

  assign pready         = 1'b1;
  assign wr_block_bytes = psel && penable && pwrite && (paddr[2] == bsa_pkg::REG_BLOCK_BYTES);

  always_comb begin
    block_bytes_d = block_bytes_q;
    if (wr_block_bytes) begin
      block_bytes_d = pwdata[bsa_pkg::BLOCK_BYTES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= bsa_pkg::BLOCK_BYTES_RESET;
    end else begin
      block_bytes_q <= block_bytes_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bsa_pkg::REG_BLOCK_BYTES) begin
      prdata = bsa_pkg::PDATA_W'(block_bytes_q);
    end
  end

  assign block_bytes_o = block_bytes_q;

endmodule

// ----- sv/bsa_free_stack.sv -----
// ----------------------------------------------------------------------------
// bsa_free_stack
// LIFO of free slot numbers held in a synchronous memory, with its fill count.
// ----------------------------------------------------------------------------
module bsa_free_stack #(
  parameter int unsigned SLOTS = 256,
  parameter int unsigned AW    = $clog2(SLOTS),
  parameter int unsigned CW    = $clog2(SLOTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          init_en_i,
  input  logic [AW-1:0] init_addr_i,
  input  logic          pop_i,
  input  logic          push_i,
  input  logic [AW-1:0] push_slot_i,
  output logic          empty_o,
  output logic [AW-1:0] pop_slot_o
);

  logic [AW-1:0] mem [SLOTS];
  logic [AW-1:0] rdata_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_d;
  logic [CW-1:0] count_m1;
  logic          not_full;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] wr_data;

  assign count_m1 = count_q - CW'(1);
  assign not_full = count_q < CW'(SLOTS);
  assign empty_o  = (count_q == '0);

  // The clearing pass loads entry i with SLOTS-1-i, leaving slot zero on top.
  assign wr_en   = init_en_i || (push_i && not_full);
  assign wr_addr = init_en_i ? init_addr_i : count_q[AW-1:0];
  assign wr_data = init_en_i ? (AW'(SLOTS - 1) - init_addr_i) : push_slot_i;

  always_comb begin
    count_d = count_q;
    if (pop_i && !empty_o) begin
      count_d = count_m1;
    end else if (push_i && not_full) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(SLOTS);
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem[count_m1[AW-1:0]];
    end
  end

  assign pop_slot_o = rdata_q;

endmodule

// ----- sv/bsa_id_map.sv -----
// ----------------------------------------------------------------------------
// bsa_id_map
// Slot owner memory (bound flag and id per slot) with a linear search engine.
// ----------------------------------------------------------------------------
module bsa_id_map #(
  parameter int unsigned SLOTS = 256,
  parameter int unsigned KEY_W = 32,
  parameter int unsigned AW    = $clog2(SLOTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic             found_o,
  output logic [AW-1:0]    found_slot_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic             wr_bound_i
);

  logic [KEY_W:0] mem [SLOTS];
  logic [KEY_W:0] rdata_q;
  logic [AW:0]    idx_q;
  logic [AW:0]    idx_d;
  logic           busy_q;
  logic           busy_d;
  logic           pend_q;
  logic           pend_d;
  logic [AW-1:0]  cmp_q;
  logic [AW-1:0]  cmp_d;
  logic           issue;
  logic           hit_now;
  logic           last_now;

  assign issue    = busy_q && (idx_q < (AW + 1)'(SLOTS));
  assign hit_now  = pend_q && rdata_q[KEY_W] && (rdata_q[KEY_W-1:0] == key_i);
  assign last_now = pend_q && (cmp_q == AW'(SLOTS - 1));
  assign done_o   = busy_q && (hit_now || last_now);
  assign found_o  = hit_now;
  assign found_slot_o = cmp_q;

  // One entry is read per cycle from slot zero upward; the compare runs in the
  // cycle after the read, so the lowest bound match is the one reported.
  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    pend_d = issue;
    cmp_d  = idx_q[AW-1:0];
    if (start_i) begin
      idx_d  = '0;
      busy_d = 1'b1;
      pend_d = 1'b0;
    end else begin
      if (issue) begin
        idx_d = idx_q + (AW + 1)'(1);
      end
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      cmp_q  <= '0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
      pend_q <= pend_d;
      cmp_q  <= cmp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_bound_i, key_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= mem[idx_q[AW-1:0]];
    end
  end

endmodule

// ----- sv/block_slot_allocator_map_unit.sv -----
// ----------------------------------------------------------------------------
// block_slot_allocator_map_unit
// Slot pool with a LIFO free stack and a block id to slot map.
// ----------------------------------------------------------------------------
// One request is handled at a time. After the request transfer the id search
// runs from slot zero upward and ends at the slot bound to the id or, when the
// id is not bound, at the last slot; the id lookup reads the owner memory one
// slot per cycle. A decide step follows, then a pop step for an allocate that
// takes a free slot, a multiply step for the byte offset and a done step. After
// reset a clearing pass initialises the free stack and the owner memory; no
// request is taken until it has finished, while configuration writes are
// accepted throughout. A finished result waits in an output register, and the
// next request is taken meanwhile.
module block_slot_allocator_map_unit #(
  parameter int unsigned SLOTS   = 256,
  parameter int unsigned ID_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bsa_req_if.sink                     req_i,
  bsa_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsa_pkg::PADDR_W-1:0] paddr,
  input  logic [bsa_pkg::PDATA_W-1:0] pwdata,
  output logic [bsa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned KEY_W = (ID_BITS < bsa_pkg::BLOCK_ID_W) ? ID_BITS
                                                                  : bsa_pkg::BLOCK_ID_W;
  localparam int unsigned BB_W  = bsa_pkg::BLOCK_BYTES_W;
  localparam int unsigned PW    = AW + BB_W;

  bsa_pkg::bsa_state_e state_q, state_d;

  logic [BB_W-1:0]               block_bytes;
  logic [AW-1:0]                 init_addr_q, init_addr_d;
  logic [bsa_pkg::OPCODE_W-1:0]  op_q, op_d;
  logic [KEY_W-1:0]              key_q, key_d;
  logic                          found_q, found_d;
  logic [AW-1:0]                 fslot_q, fslot_d;
  logic [bsa_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
  logic                          res_hit_q, res_hit_d;
  logic [AW-1:0]                 res_slot_q, res_slot_d;
  logic                          res_valid_q, res_valid_d;
  logic [bsa_pkg::OFFSET_W-1:0]  prod_q, prod_d;
  logic [PW-1:0]                 prod_full;

  logic                          out_valid_q, out_valid_d;
  logic [bsa_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic                          out_hit_q, out_hit_d;
  logic [bsa_pkg::SLOT_W-1:0]    out_slot_q, out_slot_d;
  logic [bsa_pkg::OFFSET_W-1:0]  out_offset_q, out_offset_d;

  logic                          req_xfer;
  logic                          init_en;
  logic                          map_done;
  logic                          map_found;
  logic [AW-1:0]                 map_slot;
  logic                          map_wr_en;
  logic [AW-1:0]                 map_wr_addr;
  logic                          map_wr_bound;
  logic                          stk_empty;
  logic                          stk_pop;
  logic                          stk_push;
  logic [AW-1:0]                 stk_slot;
  logic                          out_free;

  bsa_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .block_bytes_o (block_bytes)
  );

  bsa_id_map #(
    .SLOTS (SLOTS),
    .KEY_W (KEY_W),
    .AW    (AW)
  ) u_id_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (req_xfer),
    .key_i        (key_q),
    .done_o       (map_done),
    .found_o      (map_found),
    .found_slot_o (map_slot),
    .wr_en_i      (map_wr_en),
    .wr_addr_i    (map_wr_addr),
    .wr_bound_i   (map_wr_bound)
  );

  bsa_free_stack #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .CW    (CW)
  ) u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_en_i   (init_en),
    .init_addr_i (init_addr_q),
    .pop_i       (stk_pop),
    .push_i      (stk_push),
    .push_slot_i (fslot_q),
    .empty_o     (stk_empty),
    .pop_slot_o  (stk_slot)
  );

  assign req_i.ready = (state_q == bsa_pkg::S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign init_en     = (state_q == bsa_pkg::S_INIT);
  assign out_free    = !out_valid_q || rsp_o.ready;

  // Evict and allocate are resolved once the search is complete.
  assign stk_pop  = (state_q == bsa_pkg::S_DECIDE) && (op_q == bsa_pkg::OP_ALLOC)
                    && !stk_empty && !found_q;
  assign stk_push = (state_q == bsa_pkg::S_DECIDE) && (op_q == bsa_pkg::OP_EVICT) && found_q;

  always_comb begin
    map_wr_en    = 1'b0;
    map_wr_addr  = fslot_q;
    map_wr_bound = 1'b0;
    if (init_en) begin
      map_wr_en   = 1'b1;
      map_wr_addr = init_addr_q;
    end else if (stk_push) begin
      map_wr_en   = 1'b1;
    end else if (state_q == bsa_pkg::S_POP) begin
      map_wr_en    = 1'b1;
      map_wr_addr  = stk_slot;
      map_wr_bound = 1'b1;
    end
  end

  assign prod_full = {{BB_W{1'b0}}, res_slot_q} * {{AW{1'b0}}, block_bytes};

  always_comb begin
    state_d      = state_q;
    init_addr_d  = init_addr_q;
    op_d         = op_q;
    key_d        = key_q;
    found_d      = found_q;
    fslot_d      = fslot_q;
    res_status_d = res_status_q;
    res_hit_d    = res_hit_q;
    res_slot_d   = res_slot_q;
    res_valid_d  = res_valid_q;
    prod_d       = prod_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_hit_d    = out_hit_q;
    out_slot_d   = out_slot_q;
    out_offset_d = out_offset_q;

    case (state_q)
      bsa_pkg::S_INIT: begin
        init_addr_d = init_addr_q + AW'(1);
        if (init_addr_q == AW'(SLOTS - 1)) begin
          state_d = bsa_pkg::S_IDLE;
        end
      end
      bsa_pkg::S_IDLE: begin
        if (req_xfer) begin
          op_d    = req_i.opcode;
          key_d   = req_i.block_id[KEY_W-1:0];
          state_d = bsa_pkg::S_SCAN;
        end
      end
      bsa_pkg::S_SCAN: begin
        if (map_done) begin
          found_d = map_found;
          fslot_d = map_slot;
          state_d = bsa_pkg::S_DECIDE;
        end
      end
      bsa_pkg::S_DECIDE: begin
        res_status_d = bsa_pkg::ST_OK;
        res_hit_d    = found_q;
        res_slot_d   = fslot_q;
        res_valid_d  = found_q;
        state_d      = bsa_pkg::S_MUL;
        case (op_q)
          bsa_pkg::OP_ALLOC: begin
            res_valid_d = 1'b0;
            if (stk_empty) begin
              res_status_d = bsa_pkg::ST_FULL;
            end else if (found_q) begin
              res_status_d = bsa_pkg::ST_DUP;
            end else begin
              state_d = bsa_pkg::S_POP;
            end
          end
          bsa_pkg::OP_EVICT: begin
            res_hit_d = 1'b0;
            if (!found_q) begin
              res_status_d = bsa_pkg::ST_MISS;
            end
          end
          default: begin
            // Lookup, and the unused opcode handled the same way.
          end
        endcase
      end
      bsa_pkg::S_POP: begin
        res_status_d = bsa_pkg::ST_OK;
        res_hit_d    = 1'b1;
        res_slot_d   = stk_slot;
        res_valid_d  = 1'b1;
        state_d      = bsa_pkg::S_MUL;
      end
      bsa_pkg::S_MUL: begin
        prod_d  = res_valid_q ? bsa_pkg::OFFSET_W'(prod_full) : '0;
        state_d = bsa_pkg::S_DONE;
      end
      bsa_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_hit_d    = res_hit_q;
          out_slot_d   = res_valid_q ? bsa_pkg::SLOT_W'(res_slot_q) : '0;
          out_offset_d = prod_q;
          state_d      = bsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsa_pkg::S_INIT;
      init_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_addr_q <= init_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    found_q      <= found_d;
    fslot_q      <= fslot_d;
    res_status_q <= res_status_d;
    res_hit_q    <= res_hit_d;
    res_slot_q   <= res_slot_d;
    res_valid_q  <= res_valid_d;
    prod_q       <= prod_d;
    out_status_q <= out_status_d;
    out_hit_q    <= out_hit_d;
    out_slot_q   <= out_slot_d;
    out_offset_q <= out_offset_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.slot_index  = out_slot_q;
  assign rsp_o.byte_offset = out_offset_q;

endmodule

// ----- sv/bsa_checker.sv -----
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks on the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic                         req_ready_i,
  input  logic                         rsp_valid_i,
  input  logic                         rsp_ready_i,
  input  logic [bsa_pkg::STATUS_W-1:0] rsp_status_i,
  input  logic                         rsp_hit_i,
  input  logic [bsa_pkg::SLOT_W-1:0]   rsp_slot_index_i,
  input  logic [bsa_pkg::OFFSET_W-1:0] rsp_byte_offset_i
);

  // Requests are handled one at a time, so a transfer is never followed at once by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous one is still in progress");

  // Failed requests report neither a slot nor an offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != bsa_pkg::ST_OK) |-> (rsp_slot_index_i == '0)
      && (rsp_byte_offset_i == '0))
    else $error("error result carries a slot or offset");

  // A duplicate refusal means the id is bound; an unknown id on evict is not.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && ((rsp_status_i == bsa_pkg::ST_DUP) && !rsp_hit_i
      || (rsp_status_i == bsa_pkg::ST_MISS) && rsp_hit_i) |-> 1'b0)
    else $error("hit flag disagrees with status");

  // A result that is not taken stays as it is.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_hit_i) && $stable(rsp_slot_index_i) && $stable(rsp_byte_offset_i))
    else $error("stalled result changed");

endmodule

bind block_slot_allocator_map_unit bsa_checker u_bsa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_hit_i         (rsp_o.hit),
  .rsp_slot_index_i  (rsp_o.slot_index),
  .rsp_byte_offset_i (rsp_o.byte_offset)
);

// ----- bench/tb_block_slot_allocator_map_unit.sv -----
// ----------------------------------------------------------------------------
// tb_block_slot_allocator_map_unit
// Self-checking bench for the block slot allocator. A short scripted run from
// reset is followed by random allocate, lookup and evict traffic. The traffic
// fills the pool to overflow, churns it, drains it and churns it again, under
// several block sizes and handshake pressures. Each result is checked
// against its typed script value or a bench model of the free stack and id map.
// ----------------------------------------------------------------------------
module tb_block_slot_allocator_map_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS   = 256;
  localparam int unsigned ID_BITS = 32;

  // Opcode 3 has no name in the package; the block treats it as a lookup.
  localparam logic [bsa_pkg::OPCODE_W-1:0] OP_ALIAS_LOOKUP = 2'd3;

  localparam logic [bsa_pkg::PADDR_W-1:0] BLOCK_BYTES_ADDR =
    {bsa_pkg::REG_BLOCK_BYTES, 2'b00};

  typedef struct packed {
    logic [bsa_pkg::STATUS_W-1:0] status;
    logic                         hit;
    logic [bsa_pkg::SLOT_W-1:0]   slot_index;
    logic [bsa_pkg::OFFSET_W-1:0] byte_offset;
  } alloc_result_t;

  typedef struct packed {
    logic [bsa_pkg::OPCODE_W-1:0]   op;
    logic [bsa_pkg::BLOCK_ID_W-1:0] id;
    logic                           typed;
    alloc_result_t                  res;
  } script_row_t;

  // Scripted part, run from reset with the reset block size of 4096 bytes.
  localparam int SCRIPT_LEN = 20;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{bsa_pkg::OP_LOOKUP, 32'h0000_0000, 1'b1, {bsa_pkg::ST_OK,   1'b0, 8'd0, 28'd0}},
    '{bsa_pkg::OP_EVICT,  32'h0000_0000, 1'b1, {bsa_pkg::ST_MISS, 1'b0, 8'd0, 28'd0}},
    '{bsa_pkg::OP_ALLOC,  32'h0000_0000, 1'b1, {bsa_pkg::ST_OK,   1'b1, 8'd0, 28'd0}},
    '{bsa_pkg::OP_ALLOC,  32'hFFFF_FFFF, 1'b1, {bsa_pkg::ST_OK,   1'b1, 8'd1, 28'd4096}},
    '{bsa_pkg::OP_ALLOC,  32'h0000_0000, 1'b1, {bsa_pkg::ST_DUP,  1'b1, 8'd0, 28'd0}},
    '{bsa_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, {bsa_pkg::ST_OK,   1'b1, 8'd1, 28'd4096}},
    '{OP_ALIAS_LOOKUP,    32'h0000_0000, 1'b1, {bsa_pkg::ST_OK,   1'b1, 8'd0, 28'd0}},
    '{OP_ALIAS_LOOKUP,    32'h1234_5678, 1'b1, {bsa_pkg::ST_OK,   1'b0, 8'd0, 28'd0}},
    '{bsa_pkg::OP_ALLOC,  32'hA5A5_A5A5, 1'b1, {bsa_pkg::ST_OK,   1'b1, 8'd2, 28'd8192}},
    '{bsa_pkg::OP_EVICT,  32'hFFFF_FFFF, 1'b1, {bsa_pkg::ST_OK,   1'b0, 8'd1, 28'd4096}},
    '{bsa_pkg::OP_EVICT,  32'hFFFF_FFFF, 1'b1, {bsa_pkg::ST_MISS, 1'b0, 8'd0, 28'd0}},
    '{bsa_pkg::OP_ALLOC,  32'h5A5A_5A5A, 1'b1, {bsa_pkg::ST_OK,   1'b1, 8'd1, 28'd4096}},
    '{bsa_pkg::OP_LOOKUP, 32'h5A5A_5A5A, 1'b0, '0},
    '{bsa_pkg::OP_ALLOC,  32'h8000_0000, 1'b0, '0},
    '{bsa_pkg::OP_EVICT,  32'h0000_0000, 1'b0, '0},
    '{bsa_pkg::OP_EVICT,  32'hA5A5_A5A5, 1'b0, '0},
    '{bsa_pkg::OP_ALLOC,  32'h0000_0001, 1'b0, '0},
    '{bsa_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, '0},
    '{bsa_pkg::OP_ALLOC,  32'h7FFF_FFFF, 1'b0, '0},
    '{bsa_pkg::OP_EVICT,  32'h8000_0000, 1'b0, '0}
  };

  // Random part: one block size and one handshake pressure per phase.
  localparam int PHASES = 5;
  localparam int PHASE_START [PHASES+1] = '{0, 270, 540, 630, 720, 800};
  localparam logic [31:0] PHASE_BYTES [PHASES] =
    '{32'h0000_0001, 32'h0010_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000};
  localparam int PHASE_SND_IDLE [PHASES] = '{37, 45, 0, 0, 0};
  localparam int PHASE_RCV_IDLE [PHASES] = '{45, 37, 0, 0, 0};

  // Traffic mix: cumulative percentages for fresh allocate, duplicate
  // allocate, lookup of a bound id, lookup of a random id, evict of a bound
  // id and evict of a random id; the rest are opcode 3 requests.
  localparam int MODE_FILL  = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_DRAIN = 2;
  localparam int MIX_CUT [3][6] = '{
    '{76, 80, 87, 91, 95, 98},
    '{35, 42, 60, 70, 88, 94},
    '{ 8, 12, 20, 26, 86, 94}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bsa_pkg::PADDR_W-1:0]  paddr;
  logic [bsa_pkg::PDATA_W-1:0]  pwdata;
  logic [bsa_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  bsa_req_if req_if ();
  bsa_rsp_if rsp_if ();

  block_slot_allocator_map_unit #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the pool state.
  logic [bsa_pkg::SLOT_W-1:0]        model_free_stack [SLOTS];
  logic [bsa_pkg::SLOT_W:0]          model_free_count;
  logic [bsa_pkg::BLOCK_ID_W-1:0]    model_owner [SLOTS];
  logic                              model_bound [SLOTS];
  logic [bsa_pkg::BLOCK_BYTES_W-1:0] model_block_bytes;

  alloc_result_t pending_results [$];
  int            fail_count = 0;
  int            snd_idle_pct = 0;
  int            rcv_idle_pct = 0;

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic logic [bsa_pkg::OFFSET_W-1:0] slot_offset(
    input logic [bsa_pkg::SLOT_W-1:0] slot);
    logic [bsa_pkg::SLOT_W+bsa_pkg::BLOCK_BYTES_W-1:0] product;
    product = slot * model_block_bytes;
    return product[bsa_pkg::OFFSET_W-1:0];
  endfunction

  // Applies one request to the bench state and returns the result it gives.
  task automatic apply_request(input logic [bsa_pkg::OPCODE_W-1:0] op,
                               input logic [bsa_pkg::BLOCK_ID_W-1:0] id,
                               output alloc_result_t res);
    int                         found;
    logic [bsa_pkg::SLOT_W-1:0] slot;
    found = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (found < 0 && model_bound[s] && model_owner[s] == id) found = s;
    end
    res = '0;
    case (op)
      bsa_pkg::OP_ALLOC: begin
        if (model_free_count == 0) begin
          res.status = bsa_pkg::ST_FULL;
          res.hit    = (found >= 0);
        end else if (found >= 0) begin
          res.status = bsa_pkg::ST_DUP;
          res.hit    = 1'b1;
        end else begin
          model_free_count--;
          slot = model_free_stack[model_free_count];
          model_bound[slot] = 1'b1;
          model_owner[slot] = id;
          res = {bsa_pkg::ST_OK, 1'b1, slot, slot_offset(slot)};
        end
      end
      bsa_pkg::OP_EVICT: begin
        if (found < 0) begin
          res.status = bsa_pkg::ST_MISS;
        end else begin
          slot = bsa_pkg::SLOT_W'(found);
          if (model_free_count < SLOTS) begin
            model_free_stack[model_free_count] = slot;
            model_free_count++;
          end
          model_bound[slot] = 1'b0;
          res = {bsa_pkg::ST_OK, 1'b0, slot, slot_offset(slot)};
        end
      end
      default: begin
        if (found >= 0) begin
          slot = bsa_pkg::SLOT_W'(found);
          res = {bsa_pkg::ST_OK, 1'b1, slot, slot_offset(slot)};
        end
      end
    endcase
  endtask

  function automatic logic [bsa_pkg::BLOCK_ID_W-1:0] random_block_id();
    // A share of small ids makes accidental duplicates likely.
    if ($urandom_range(0, 3) == 0) return bsa_pkg::BLOCK_ID_W'($urandom_range(0, 15));
    return $urandom();
  endfunction

  function automatic logic [bsa_pkg::BLOCK_ID_W-1:0] bound_or_random_id();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      if (model_bound[(start + k) % SLOTS]) return model_owner[(start + k) % SLOTS];
    end
    return random_block_id();
  endfunction

  // One request transfer; the expectation is queued at the accepting edge.
  task automatic send_request(input logic [bsa_pkg::OPCODE_W-1:0] op,
                              input logic [bsa_pkg::BLOCK_ID_W-1:0] id,
                              input logic typed,
                              input alloc_result_t typed_res);
    alloc_result_t pred;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.block_id <= id;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    apply_request(op, id, pred);
    pending_results = {pending_results, (typed ? typed_res : pred)};
  endtask

  task automatic apb_transfer(input logic wr, input logic [bsa_pkg::PDATA_W-1:0] wdata,
                              output logic [bsa_pkg::PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= BLOCK_BYTES_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk) begin
    alloc_result_t seen;
    alloc_result_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
      seen = {rsp_if.status, rsp_if.hit, rsp_if.slot_index, rsp_if.byte_offset};
      if (pending_results.size() == 0) begin
        report_failure("result transfer with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          report_failure($sformatf(
            "expected st=%0d hit=%0d slot=%0d off=%0h, got st=%0d hit=%0d slot=%0d off=%0h",
            want.status, want.hit, want.slot_index, want.byte_offset,
            seen.status, seen.hit, seen.slot_index, seen.byte_offset));
        end
      end
    end
    rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  initial begin
    logic [bsa_pkg::PDATA_W-1:0]    wdata;
    logic [bsa_pkg::PDATA_W-1:0]    rdata;
    logic [bsa_pkg::OPCODE_W-1:0]   op;
    logic [bsa_pkg::BLOCK_ID_W-1:0] id;
    int                             roll;
    int                             mode;

    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.opcode   = bsa_pkg::OP_ALLOC;
    req_if.block_id = '0;
    rsp_if.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;

    for (int i = 0; i < SLOTS; i++) begin
      model_free_stack[i] = bsa_pkg::SLOT_W'(SLOTS - 1 - i);
      model_owner[i]      = '0;
      model_bound[i]      = 1'b0;
    end
    model_free_count  = (bsa_pkg::SLOT_W + 1)'(SLOTS);
    model_block_bytes = bsa_pkg::BLOCK_BYTES_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    apb_transfer(1'b0, '0, rdata);
    if (rdata !== bsa_pkg::PDATA_W'(bsa_pkg::BLOCK_BYTES_RESET)) begin
      report_failure($sformatf("block size after reset reads %0h", rdata));
    end

    snd_idle_pct = PHASE_SND_IDLE[0];
    rcv_idle_pct = PHASE_RCV_IDLE[0];
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_request(SCRIPT[i].op, SCRIPT[i].id, SCRIPT[i].typed, SCRIPT[i].res);
    end

    for (int p = 0; p < PHASES; p++) begin
      // The block size only changes once the block has gone idle.
      req_if.valid <= 1'b0;
      wait_drained();
      wdata = (p == PHASES - 1) ? $urandom() : PHASE_BYTES[p];
      apb_transfer(1'b1, wdata, rdata);
      model_block_bytes = wdata[bsa_pkg::BLOCK_BYTES_W-1:0];
      apb_transfer(1'b0, '0, rdata);
      if (rdata !== bsa_pkg::PDATA_W'(wdata[bsa_pkg::BLOCK_BYTES_W-1:0])) begin
        report_failure($sformatf("block size wrote %0h, reads %0h", wdata, rdata));
      end
      snd_idle_pct = PHASE_SND_IDLE[p];
      rcv_idle_pct = PHASE_RCV_IDLE[p];

      for (int n = PHASE_START[p]; n < PHASE_START[p+1]; n++) begin
        // Fill past overflow, churn, drain, then churn again.
        mode = (n < 400) ? MODE_FILL : (n < 500) ? MODE_MIXED :
               (n < 750) ? MODE_DRAIN : MODE_MIXED;
        roll = $urandom_range(0, 99);
        if (roll < MIX_CUT[mode][0]) begin
          op = bsa_pkg::OP_ALLOC;
          id = random_block_id();
        end else if (roll < MIX_CUT[mode][1]) begin
          op = bsa_pkg::OP_ALLOC;
          id = bound_or_random_id();
        end else if (roll < MIX_CUT[mode][2]) begin
          op = bsa_pkg::OP_LOOKUP;
          id = bound_or_random_id();
        end else if (roll < MIX_CUT[mode][3]) begin
          op = bsa_pkg::OP_LOOKUP;
          id = random_block_id();
        end else if (roll < MIX_CUT[mode][4]) begin
          op = bsa_pkg::OP_EVICT;
          id = bound_or_random_id();
        end else if (roll < MIX_CUT[mode][5]) begin
          op = bsa_pkg::OP_EVICT;
          id = random_block_id();
        end else begin
          op = OP_ALIAS_LOOKUP;
          id = $urandom_range(0, 1) ? bound_or_random_id() : random_block_id();
        end
        send_request(op, id, 1'b0, '0);
      end
    end

    req_if.valid <= 1'b0;
    wait_drained();
    repeat (SLOTS + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
